FILE: sv/qcpm_pkg.sv
// Package for the quad cascaded PID mixer: register indexes, widths and constants.
// Used by the serial multiplier and the top level; depends on nothing.
package qcpm_pkg;

    localparam int GAIN_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 120;
    localparam int OUT_TDATA_W = 64;
    localparam int MUL_A_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRUST   = 3'd0,
        REG_PITCH_KP = 3'd1,
        REG_ROLL_KP  = 3'd2,
        REG_YAW_KP   = 3'd3,
        REG_ANGLE_KI = 3'd4,
        REG_ANGLE_KD = 3'd5,
        REG_RATE_KP  = 3'd6,
        REG_RATE_KD  = 3'd7
    } cfg_reg_t;

    localparam logic signed [15:0] THRUST_RST = 16'sd20;
    localparam logic [31:0] PITCH_KP_RST = 32'd18350080;
    localparam logic [31:0] ROLL_KP_RST = 32'd16384000;
    localparam logic [31:0] YAW_KP_RST = 32'd98304;
    localparam logic [31:0] RATE_KP_RST = 32'd2621;
    localparam logic [31:0] RATE_KD_RST = 32'd131;
    localparam logic [31:0] YAW_INNER_KP = 32'd3015;
    localparam logic [31:0] YAW_INNER_KD = 32'd786;
    localparam int TARGET_CENTER = 1500;
    localparam int INTEG_LIMIT = 76800;

    typedef struct packed {
        logic start;
        logic signed [MUL_A_W-1:0] a;
        logic [GAIN_W-1:0] b;
    } mul_req_t;

endpackage

FILE: sv/quad_cascaded_pid_mixer_top.sv
// Top level of the quad cascaded PID attitude controller with quad-X mixer.
// Depends on qcpm_pkg and qcpm_mul.
//
// One input beat on s_axis carries a control tick (angles, gyro rates, stick
// pulses); one output beat on m_axis carries four saturated motor values.
// Work runs through one shared bit-serial multiplier that retires one gain bit
// per cycle; a tick needs thirteen products, each taking a set-up step, the
// shift-add steps and a collect step.
// One tick is processed at a time: s_axis_tready is high only while the
// controller is idle.
// The result is held in an output register until m_axis_tready takes it; a
// stalled receiver holds tdata steady, and a following tick is computed but
// waits in its last step until the output register is free.
// Reset restores the register defaults and clears integrals and history.
// Configuration is written through cfg_we, cfg_addr and cfg_data, taking
// effect at once; every value of the three-bit cfg_addr selects a register.
module quad_cascaded_pid_mixer_top
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pitch_angle, roll_angle, gyro_x, gyro_y, gyro_z, stick_pitch, stick_roll, stick_yaw
    input  logic [qcpm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
    output logic [qcpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic cfg_we,
    input  logic [qcpm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [qcpm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = qcpm_pkg::MUL_A_W + qcpm_pkg::GAIN_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MUL, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_PITCH_P, OP_PITCH_I, OP_PITCH_D, OP_ROLL_P, OP_ROLL_I, OP_ROLL_D, OP_YAW_P,
        OP_PITCH_RATE_P, OP_PITCH_RATE_D, OP_ROLL_RATE_P, OP_ROLL_RATE_D,
        OP_YAW_RATE_P, OP_YAW_RATE_D
    } op_t;

    state_t state_reg;
    op_t op_reg;
    logic out_valid_reg;
    logic [qcpm_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic signed [15:0] thrust_reg;
    logic [31:0] pkp_reg, rkp_reg, ykp_reg, ki_reg, kd_reg, rate_kp_reg, rate_kd_reg;

    logic signed [23:0] pint_reg, rint_reg;
    logic signed [16:0] lpa_reg, lra_reg;
    logic signed [15:0] lrx_reg, lry_reg, lrz_reg;

    logic signed [16:0] pa_reg, ra_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic signed [17:0] perr_reg, rerr_reg;
    logic signed [17:0] pd_reg, rd_reg;
    logic signed [23:0] pint_new_reg, rint_new_reg;
    logic signed [20:0] yerr_reg;
    logic signed [PW+2:0] sum_reg;
    logic signed [31:0] pout_reg, rout_reg, yout_reg;
    logic signed [PW+2:0] pcore_reg, rcore_reg, ycore_reg;

    qcpm_pkg::mul_req_t req;
    logic mul_busy;
    logic signed [PW-1:0] prod;

    qcpm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .busy  (mul_busy),
        .prod  (prod)
    );

    function automatic logic signed [31:0] sat32(input logic signed [PW+2:0] x);
        if (x > (PW+3)'(64'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < -(PW+3)'(64'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [15:0] motor(input logic signed [PW+2:0] m);
        logic signed [PW+2:0] q;
        q = m >>> 16;
        if (m < 0 && m[15:0] != '0)
        begin
            q = q + 1;
        end
        if (q > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (q < -32768)
        begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    function automatic logic signed [23:0] clampi(input logic signed [24:0] x);
        if (x > 25'(qcpm_pkg::INTEG_LIMIT))
        begin
            return 24'(qcpm_pkg::INTEG_LIMIT);
        end
        else if (x < -25'(qcpm_pkg::INTEG_LIMIT))
        begin
            return -24'(qcpm_pkg::INTEG_LIMIT);
        end
        return x[23:0];
    endfunction

    // Angle target (rc - 1500) * 256 / 20 rounded toward zero, via a reciprocal
    // multiplication on a narrow value.
    function automatic logic signed [16:0] target(input logic [11:0] rc);
        logic signed [13:0] c;
        logic [12:0] mag;
        logic [20:0] q;
        c = $signed({2'b00, rc}) - 14'sd1500;
        mag = c[13] ? 13'(-c) : 13'(c);
        q = 21'((40'(mag) * 40'd53687104) >> 22);
        return c[13] ? -17'(q) : 17'(q);
    endfunction

    logic signed [16:0] pin, rin;
    logic signed [15:0] gxi, gyi, gzi;
    logic [11:0] rcp, rcr, rcy;
    assign pin = s_axis_tdata[16:0];
    assign rin = s_axis_tdata[33:17];
    assign gxi = s_axis_tdata[49:34];
    assign gyi = s_axis_tdata[65:50];
    assign gzi = s_axis_tdata[81:66];
    assign rcp = s_axis_tdata[93:82];
    assign rcr = s_axis_tdata[105:94];
    assign rcy = s_axis_tdata[117:106];

    logic in_acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    logic signed [PW+2:0] prod_x;
    logic signed [PW+2:0] fl8;
    assign prod_x = (PW+3)'(prod);
    assign fl8 = prod_x >>> 8;

    // Operand and gain for each product in sequence.
    always_comb
    begin
        req.start = 1'b0;
        req.a = '0;
        req.b = '0;
        if (state_reg == ST_PREP)
        begin
            req.start = 1'b1;
            case (op_reg)
                OP_PITCH_P: begin req.a = 40'(perr_reg); req.b = pkp_reg; end
                OP_PITCH_I: begin req.a = 40'(pint_new_reg); req.b = ki_reg; end
                OP_PITCH_D: begin req.a = 40'(pd_reg); req.b = kd_reg; end
                OP_ROLL_P: begin req.a = 40'(rerr_reg); req.b = rkp_reg; end
                OP_ROLL_I: begin req.a = 40'(rint_new_reg); req.b = ki_reg; end
                OP_ROLL_D: begin req.a = 40'(rd_reg); req.b = kd_reg; end
                OP_YAW_P: begin req.a = 40'(yerr_reg); req.b = ykp_reg; end
                OP_PITCH_RATE_P: begin req.a = 40'(pout_reg); req.b = rate_kp_reg; end
                OP_PITCH_RATE_D:
                begin
                    req.a = 40'(17'(gy_reg) - 17'(lry_reg));
                    req.b = rate_kd_reg;
                end
                OP_ROLL_RATE_P: begin req.a = 40'(rout_reg); req.b = rate_kp_reg; end
                OP_ROLL_RATE_D:
                begin
                    req.a = 40'(17'(gx_reg) - 17'(lrx_reg));
                    req.b = rate_kd_reg;
                end
                OP_YAW_RATE_P:
                begin
                    req.a = 40'(yout_reg);
                    req.b = qcpm_pkg::YAW_INNER_KP;
                end
                OP_YAW_RATE_D:
                begin
                    req.a = 40'(17'(gz_reg) - 17'(lrz_reg));
                    req.b = qcpm_pkg::YAW_INNER_KD;
                end
                default: begin req.a = '0; req.b = '0; end
            endcase
        end
    end

    logic signed [PW+2:0] thr, mc0, mc1, mc2, mc3;
    assign thr = (PW+3)'(thrust_reg) <<< 16;
    assign mc0 = thr - rcore_reg - pcore_reg - ycore_reg;
    assign mc1 = thr + rcore_reg - pcore_reg + ycore_reg;
    assign mc2 = thr + rcore_reg + pcore_reg - ycore_reg;
    assign mc3 = thr - rcore_reg + pcore_reg + ycore_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_PITCH_P;
            out_valid_reg <= 1'b0;
            thrust_reg <= qcpm_pkg::THRUST_RST;
            pkp_reg <= qcpm_pkg::PITCH_KP_RST;
            rkp_reg <= qcpm_pkg::ROLL_KP_RST;
            ykp_reg <= qcpm_pkg::YAW_KP_RST;
            ki_reg <= '0;
            kd_reg <= '0;
            rate_kp_reg <= qcpm_pkg::RATE_KP_RST;
            rate_kd_reg <= qcpm_pkg::RATE_KD_RST;
            pint_reg <= '0;
            rint_reg <= '0;
            lpa_reg <= '0;
            lra_reg <= '0;
            lrx_reg <= '0;
            lry_reg <= '0;
            lrz_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (qcpm_pkg::cfg_reg_t'(cfg_addr))
                    qcpm_pkg::REG_THRUST:   thrust_reg <= cfg_data[15:0];
                    qcpm_pkg::REG_PITCH_KP: pkp_reg <= cfg_data;
                    qcpm_pkg::REG_ROLL_KP:  rkp_reg <= cfg_data;
                    qcpm_pkg::REG_YAW_KP:   ykp_reg <= cfg_data;
                    qcpm_pkg::REG_ANGLE_KI: ki_reg <= cfg_data;
                    qcpm_pkg::REG_ANGLE_KD: kd_reg <= cfg_data;
                    qcpm_pkg::REG_RATE_KP:  rate_kp_reg <= cfg_data;
                    qcpm_pkg::REG_RATE_KD:  rate_kd_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        pa_reg <= pin;
                        ra_reg <= rin;
                        gx_reg <= gxi;
                        gy_reg <= gyi;
                        gz_reg <= gzi;
                        perr_reg <= 18'(pin) - 18'(target(rcp));
                        rerr_reg <= 18'(rin) - 18'(target(rcr));
                        pd_reg <= 18'(pin) - 18'(lpa_reg);
                        rd_reg <= 18'(rin) - 18'(lra_reg);
                        yerr_reg <= 21'(gzi) - 21'($signed({2'b00, rcy}) - 14'sd1500) * 21'sd10;
                        op_reg <= OP_PITCH_P;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (op_reg == OP_PITCH_P)
                    begin
                        pint_new_reg <= clampi(25'(pint_reg) + 25'(perr_reg));
                        rint_new_reg <= clampi(25'(rint_reg) + 25'(rerr_reg));
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (!mul_busy)
                    begin
                        case (op_reg) inside
                            OP_PITCH_P, OP_ROLL_P: sum_reg <= prod_x;
                            OP_PITCH_I, OP_ROLL_I: sum_reg <= sum_reg + prod_x;
                            OP_PITCH_D: pout_reg <= sat32((sum_reg + prod_x) >>> 16);
                            OP_ROLL_D: rout_reg <= sat32((sum_reg + prod_x) >>> 16);
                            // The inner P operand takes the feed-forward first.
                            OP_YAW_P:
                            begin
                                pout_reg <= sat32((PW+3)'(pout_reg) + (PW+3)'(gy_reg) * 896);
                                rout_reg <= sat32((PW+3)'(rout_reg) + (PW+3)'(gx_reg) * 896);
                                yout_reg <= sat32((PW+3)'(sat32(fl8)) + (PW+3)'(gz_reg) * 256);
                            end
                            OP_PITCH_RATE_P: pcore_reg <= fl8;
                            OP_PITCH_RATE_D: pcore_reg <= pcore_reg + prod_x;
                            OP_ROLL_RATE_P: rcore_reg <= fl8;
                            OP_ROLL_RATE_D: rcore_reg <= rcore_reg + prod_x;
                            OP_YAW_RATE_P: ycore_reg <= fl8;
                            default: ycore_reg <= ycore_reg + prod_x;
                        endcase
                        op_reg <= (op_reg == OP_YAW_RATE_D) ? OP_PITCH_P
                                                            : op_t'(op_reg + 4'd1);
                        state_reg <= (op_reg == OP_YAW_RATE_D) ? ST_DONE : ST_PREP;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg <= {motor(mc3), motor(mc2), motor(mc1), motor(mc0)};
                        out_valid_reg <= 1'b1;
                        pint_reg <= pint_new_reg;
                        rint_reg <= rint_new_reg;
                        lpa_reg <= pa_reg;
                        lra_reg <= ra_reg;
                        lrx_reg <= gx_reg;
                        lry_reg <= gy_reg;
                        lrz_reg <= gz_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_PREP)
        else $error("accepted tick did not start");

endmodule

FILE: sv/qcpm_mul.sv
// Bit-serial signed by unsigned multiplier, one gain bit per cycle.
// Depends on qcpm_pkg.
module qcpm_mul
(
    input  logic clk,
    input  logic rst_n,
    input  qcpm_pkg::mul_req_t req,
    output logic busy,
    output logic signed [qcpm_pkg::MUL_A_W+qcpm_pkg::GAIN_W:0] prod
);

    localparam int PW = qcpm_pkg::MUL_A_W + qcpm_pkg::GAIN_W + 1;

    logic signed [qcpm_pkg::MUL_A_W-1:0] a_reg;
    logic [qcpm_pkg::GAIN_W-1:0] b_reg;
    logic signed [PW-1:0] acc_reg;
    logic [5:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= 6'(qcpm_pkg::GAIN_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[qcpm_pkg::GAIN_W-1])
            begin
                acc_reg <= (acc_reg <<< 1) + PW'(a_reg);
            end
            else
            begin
                acc_reg <= acc_reg <<< 1;
            end
            b_reg <= b_reg << 1;
        end
    end

    assign busy = (cnt_reg != '0) || req.start;
    assign prod = acc_reg;

endmodule
